// ===== rtl/cmfta_pkg.sv =====
package cmfta_pkg;

   // defaults for the top level parameters
   localparam int MAX_FACE_DIM_DEFAULT   = 4096;
   localparam int COMPONENT_BITS_DEFAULT = 16;

   // configuration registers
   localparam int CSR_DATA_W  = 13;
   localparam int CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_FACE_WIDTH  = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FACE_HEIGHT = 1'd1;
   localparam logic [CSR_DATA_W-1:0]  FACE_SIZE_RESET = 13'd512;
   localparam int CSR_DATA_MAX = 8191;

   // result field widths
   localparam int FACE_W   = 3;
   localparam int TEXEL_W  = 12;
   localparam int OFFSET_W = 24;
   localparam int RSP_FIELDS_W = FACE_W + 2 * TEXEL_W + OFFSET_W;
   localparam int RSP_DATA_W   = ((RSP_FIELDS_W + 7) / 8) * 8;

   // face codes
   localparam logic [FACE_W-1:0] FACE_POS_X = 3'd0;
   localparam logic [FACE_W-1:0] FACE_NEG_X = 3'd1;
   localparam logic [FACE_W-1:0] FACE_POS_Y = 3'd2;
   localparam logic [FACE_W-1:0] FACE_NEG_Y = 3'd3;
   localparam logic [FACE_W-1:0] FACE_POS_Z = 3'd4;
   localparam logic [FACE_W-1:0] FACE_NEG_Z = 3'd5;

endpackage

// ===== rtl/cube_map_face_texel_address_core.sv =====
// Cube-map face selection and texel addressing. Each request beat carries a
// signed direction (dir_x, dir_y, dir_z). The face whose axis component is
// strictly largest in magnitude is chosen, the two minor components are mapped
// to a texel column and row floor((s+m)*size/(2m)) clamped to size-1, and the
// linear index texel_x + face_width*texel_y is formed. A tie or a zero vector
// gives face_hit=0 with all other fields 0 (fallback color). Sizes are written
// through the csr port (index 0 face_width, 1 face_height, reset 512); a 0 is
// used as 1 and values above MAX_FACE_DIM saturate. Write them only while the
// pipeline is empty. Throughput is one beat per cycle while the output is not
// stalled. The restoring divider resolves one quotient bit per pipeline stage.
// Each stage holds its beat under back-pressure and bubbles collapse, so new
// beats keep entering while a finished result waits in the output stage, until
// every stage holds a beat.
module cube_map_face_texel_address_core
   import cmfta_pkg::*;
#(
   parameter int MAX_FACE_DIM   = MAX_FACE_DIM_DEFAULT,
   parameter int COMPONENT_BITS = COMPONENT_BITS_DEFAULT,
   localparam int REQ_DATA_W    = ((3 * COMPONENT_BITS + 7) / 8) * 8
) (
   input  logic                         clock,
   input  logic                         reset,
   // request: dir_x, dir_y, dir_z (COMPONENT_BITS each, signed), from bit 0 up
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [REQ_DATA_W-1:0]        req_tdata,
   // response: face_index[2:0], texel_x[14:3], texel_y[26:15],
   // texel_offset[50:27], zero padding above
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [RSP_DATA_W-1:0]        rsp_tdata,
   // response flag: face_hit
   output logic [0:0]                   rsp_tuser,
   // configuration writes
   input  logic                         csr_we,
   input  logic [CSR_INDEX_W-1:0]       csr_index,
   input  logic [CSR_DATA_W-1:0]        csr_wdata
);

   localparam int CB         = COMPONENT_BITS;
   // largest effective face size and the widths that follow from it
   localparam int SIZE_MAX   = (MAX_FACE_DIM < CSR_DATA_MAX) ? MAX_FACE_DIM : CSR_DATA_MAX;
   localparam int SIZE_W     = $clog2(SIZE_MAX + 1);
   localparam int QUOT_W     = (SIZE_MAX > 1) ? $clog2(SIZE_MAX) : 1;
   // remainder width: numerator*size and the shifted divisor both fit
   localparam int REM_W      = CB + 1 + SIZE_W;
   localparam int PROD_W     = SIZE_W + QUOT_W;
   localparam int OFF_W      = PROD_W + 1;

   // stage map
   localparam int ST_SEL   = 0;             // major axis, face, minor components
   localparam int ST_NUM   = 1;             // s+m, t+m and divisor 2m
   localparam int ST_MUL   = 2;             // numerator times face size
   localparam int ST_DIV0  = 3;             // first quotient bit
   localparam int ST_CLAMP = ST_DIV0 + QUOT_W;
   localparam int ST_OFFM  = ST_CLAMP + 1;  // face_width * texel_y
   localparam int ST_OFFA  = ST_OFFM + 1;   // add texel_x, output stage
   localparam int N_ST     = ST_OFFA + 1;

   typedef struct packed {
      logic                     hit;
      logic [FACE_W-1:0]        face;
      logic [CB-1:0]            mag;      // major magnitude m
      logic signed [CB:0]       s;
      logic signed [CB:0]       t;
      logic [CB-1:0]            num_s;
      logic [CB-1:0]            num_t;
      logic [CB:0]              div;      // 2m
      logic [REM_W-1:0]         rem_s;
      logic [REM_W-1:0]         rem_t;
      logic [QUOT_W-1:0]        quo_s;
      logic [QUOT_W-1:0]        quo_t;
      logic [PROD_W-1:0]        prod;
      logic [OFF_W-1:0]         off;
   } pipe_type;

   // effective face size: 0 reads as 1, large values saturate
   function automatic logic [SIZE_W-1:0] eff_size(input logic [CSR_DATA_W-1:0] v);
      logic [SIZE_W-1:0] r;
      if (v == '0) begin
         r = SIZE_W'(1);
      end else if (int'(v) > SIZE_MAX) begin
         r = SIZE_W'(SIZE_MAX);
      end else begin
         r = SIZE_W'(v);
      end
      return r;
   endfunction

   logic [SIZE_W-1:0] width_ff;
   logic [SIZE_W-1:0] height_ff;

   // sizes are stored already saturated
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= eff_size(FACE_SIZE_RESET);
         height_ff <= eff_size(FACE_SIZE_RESET);
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_FACE_WIDTH:  width_ff  <= eff_size(csr_wdata);
            CSR_FACE_HEIGHT: height_ff <= eff_size(csr_wdata);
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // stage 0: face selection
   // ---------------------------------------------------------------------
   logic signed [CB-1:0] dir_x;
   logic signed [CB-1:0] dir_y;
   logic signed [CB-1:0] dir_z;
   assign dir_x = req_tdata[CB-1:0];
   assign dir_y = req_tdata[2*CB-1:CB];
   assign dir_z = req_tdata[3*CB-1:2*CB];

   pipe_type sel_in;

   always_comb begin
      logic signed [CB:0] ex, ey, ez;
      logic [CB-1:0]      ax, ay, az;
      ex = (CB+1)'(dir_x);
      ey = (CB+1)'(dir_y);
      ez = (CB+1)'(dir_z);
      // magnitude of the most negative value still fits in CB unsigned bits
      ax = CB'(ex[CB] ? -ex : ex);
      ay = CB'(ey[CB] ? -ey : ey);
      az = CB'(ez[CB] ? -ez : ez);
      sel_in      = '0;
      sel_in.hit  = 1'b1;
      if (ax > ay && ax > az) begin
         sel_in.mag  = ax;
         sel_in.face = ex[CB] ? FACE_NEG_X : FACE_POS_X;
         sel_in.s    = ex[CB] ? ez : -ez;
         sel_in.t    = ey;
      end else if (ay > ax && ay > az) begin
         sel_in.mag  = ay;
         sel_in.face = ey[CB] ? FACE_NEG_Y : FACE_POS_Y;
         sel_in.s    = ex;
         sel_in.t    = ey[CB] ? ez : -ez;
      end else if (az > ax && az > ay) begin
         sel_in.mag  = az;
         sel_in.face = ez[CB] ? FACE_NEG_Z : FACE_POS_Z;
         sel_in.s    = ez[CB] ? -ex : ex;
         sel_in.t    = ey;
      end else begin
         // tie or zero vector: fallback, face stays 0
         sel_in.hit  = 1'b0;
      end
   end

   // ---------------------------------------------------------------------
   // stage logic
   // ---------------------------------------------------------------------
   pipe_type pipe_ff [N_ST];
   pipe_type pipe_in [N_ST];
   logic     valid_ff [N_ST];
   logic     stage_rdy [N_ST+1];

   always_comb begin
      logic signed [CB+1:0] sum_s, sum_t;
      logic [REM_W-1:0]     dsh;
      logic [QUOT_W-1:0]    qbit;
      pipe_type             p;
      int                   bit_pos;
      pipe_in[ST_SEL] = sel_in;
      for (int k = 1; k < N_ST; k++) begin
         p = pipe_ff[k-1];
         sum_s = '0;
         sum_t = '0;
         dsh   = '0;
         qbit  = '0;
         bit_pos = 0;
         if (k == ST_NUM) begin
            sum_s   = (CB+2)'(p.s) + (CB+2)'(signed'({1'b0, p.mag}));
            sum_t   = (CB+2)'(p.t) + (CB+2)'(signed'({1'b0, p.mag}));
            p.num_s = sum_s[CB+1] ? '0 : CB'(sum_s);
            p.num_t = sum_t[CB+1] ? '0 : CB'(sum_t);
            p.div   = {p.mag, 1'b0};
         end else if (k == ST_MUL) begin
            p.rem_s = REM_W'(p.num_s) * REM_W'(width_ff);
            p.rem_t = REM_W'(p.num_t) * REM_W'(height_ff);
            p.quo_s = '0;
            p.quo_t = '0;
         end else if (k >= ST_DIV0 && k < ST_CLAMP) begin
            // restoring division, one quotient bit per stage, msb first
            bit_pos = ST_DIV0 + QUOT_W - 1 - k;
            dsh  = REM_W'(p.div) << bit_pos;
            qbit = QUOT_W'(1) << bit_pos;
            if (p.rem_s >= dsh) begin
               p.rem_s = p.rem_s - dsh;
               p.quo_s = p.quo_s | qbit;
            end
            if (p.rem_t >= dsh) begin
               p.rem_t = p.rem_t - dsh;
               p.quo_t = p.quo_t | qbit;
            end
         end else if (k == ST_CLAMP) begin
            if ((SIZE_W+1)'(p.quo_s) > (SIZE_W+1)'(width_ff - 1'b1)) begin
               p.quo_s = QUOT_W'(width_ff - 1'b1);
            end
            if ((SIZE_W+1)'(p.quo_t) > (SIZE_W+1)'(height_ff - 1'b1)) begin
               p.quo_t = QUOT_W'(height_ff - 1'b1);
            end
            if (!p.hit) begin
               p.quo_s = '0;
               p.quo_t = '0;
            end
         end else if (k == ST_OFFM) begin
            p.prod = PROD_W'(width_ff) * PROD_W'(p.quo_t);
         end else if (k == ST_OFFA) begin
            p.off = OFF_W'(p.prod) + OFF_W'(p.quo_s);
         end
         pipe_in[k] = p;
      end
   end

   // a stage takes a new beat when it is empty or its beat moves on
   always_comb begin
      stage_rdy[N_ST] = rsp_tready;
      for (int k = N_ST - 1; k >= 0; k--) begin
         stage_rdy[k] = !valid_ff[k] || stage_rdy[k+1];
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < N_ST; k++) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (stage_rdy[k]) begin
            valid_ff[k] <= (k == 0) ? req_tvalid : valid_ff[(k == 0) ? 0 : k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < N_ST; k++) begin
         if (stage_rdy[k]) begin
            pipe_ff[k] <= pipe_in[k];
         end
      end
   end

   // ---------------------------------------------------------------------
   // ports
   // ---------------------------------------------------------------------
   pipe_type out_p;
   assign out_p      = pipe_ff[ST_OFFA];
   assign req_tready = stage_rdy[0];
   assign rsp_tvalid = valid_ff[ST_OFFA];
   assign rsp_tuser  = out_p.hit;
   assign rsp_tdata  = RSP_DATA_W'({OFFSET_W'(out_p.off),
                                    TEXEL_W'(out_p.quo_t),
                                    TEXEL_W'(out_p.quo_s),
                                    out_p.face});

   // ---------------------------------------------------------------------
   // assertions
   // ---------------------------------------------------------------------
   // an accepted beat lands in the first stage
   a_accept_lands: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> valid_ff[ST_SEL])
      else $error("accepted beat lost at pipeline entry");

   // a fallback result carries all-zero fields
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata == '0)
      else $error("fallback result with nonzero fields");

   // a hit stays on the face grid
   a_hit_in_face: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |->
         (SIZE_W+1)'(out_p.quo_s) < (SIZE_W+1)'(width_ff) &&
         (SIZE_W+1)'(out_p.quo_t) < (SIZE_W+1)'(height_ff) &&
         out_p.face <= FACE_NEG_Z)
      else $error("texel outside selected face");

   // a stalled output stage keeps its beat
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(out_p))
      else $error("output stage dropped or changed a stalled beat");

endmodule
